// ----- design/dwe_pkg.sv -----
package dwe_pkg;

	// Default pulse count width
	localparam int COUNT_BITS_DEF = 16;

	// APB register map
	localparam int APB_ADDR_BITS = 5;
	localparam int APB_DATA_BITS = 32;

	typedef enum logic [2:0] {
		REG_LOW_BATTERY_LEVEL  = 3'd0,
		REG_LOW_BATTERY_REPEAT = 3'd1,
		REG_THRESHOLD_FLOOR    = 3'd2,
		REG_THRESHOLD_CEILING  = 3'd3,
		REG_METER_CENTER       = 3'd4
	} reg_idx_t;

	// Register reset values
	localparam logic [7:0] LOW_BATTERY_LEVEL_RST  = 8'd200;
	localparam logic [9:0] LOW_BATTERY_REPEAT_RST = 10'd1000;
	localparam logic [6:0] THRESHOLD_FLOOR_RST    = 7'd2;
	localparam logic [6:0] THRESHOLD_CEILING_RST  = 7'd125;
	localparam logic [7:0] METER_CENTER_RST       = 8'd127;

	// Evaluator state reset values
	localparam int         BASELINE_RST  = 127;
	localparam logic [6:0] THRESHOLD_RST = 7'd2;

	// Deviation clamp limits
	localparam int DEV_MIN = -127;
	localparam int DEV_MAX = 128;

	typedef enum logic [1:0] {
		TONE_SILENT = 2'd0,
		TONE_FAST   = 2'd1,
		TONE_SLOW   = 2'd2
	} tone_t;

	typedef struct packed {
		logic [7:0] low_battery_level;
		logic [9:0] low_battery_repeat;
		logic [6:0] threshold_floor;
		logic [6:0] threshold_ceiling;
		logic [7:0] meter_center;
	} cfg_t;

	typedef struct packed {
		logic [7:0] meter_duty;
		tone_t      tone_mode;
		logic       detect_led;
		logic       low_battery_alarm;
		logic       sensor_error;
		logic [6:0] active_threshold;
	} result_t;

endpackage

// ----- design/dwe_if.sv -----
// Window summary channel
interface dwe_win_if #(
	parameter int COUNT_BITS = dwe_pkg::COUNT_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [COUNT_BITS-1:0] count_first;
	logic [COUNT_BITS-1:0] count_second;
	logic                  low_sensitivity;
	logic                  zero_request;
	logic [6:0]            threshold_raw;
	logic [7:0]            battery_level;

	modport source (
		output valid, count_first, count_second, low_sensitivity, zero_request,
			threshold_raw, battery_level,
		input ready
	);
	modport sink (
		input valid, count_first, count_second, low_sensitivity, zero_request,
			threshold_raw, battery_level,
		output ready
	);
endinterface

// Evaluation result channel
interface dwe_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] meter_duty;
	logic [1:0] tone_mode;
	logic       detect_led;
	logic       low_battery_alarm;
	logic       sensor_error;
	logic [6:0] active_threshold;

	modport source (
		output valid, meter_duty, tone_mode, detect_led, low_battery_alarm,
			sensor_error, active_threshold,
		input ready
	);
	modport sink (
		input valid, meter_duty, tone_mode, detect_led, low_battery_alarm,
			sensor_error, active_threshold,
		output ready
	);
endinterface

// ----- design/dwe_regs.sv -----
module dwe_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [dwe_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [dwe_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [dwe_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                pready,
	output dwe_pkg::cfg_t                       cfg
);

	dwe_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_battery_level  <= dwe_pkg::LOW_BATTERY_LEVEL_RST;
			cfg_q.low_battery_repeat <= dwe_pkg::LOW_BATTERY_REPEAT_RST;
			cfg_q.threshold_floor    <= dwe_pkg::THRESHOLD_FLOOR_RST;
			cfg_q.threshold_ceiling  <= dwe_pkg::THRESHOLD_CEILING_RST;
			cfg_q.meter_center       <= dwe_pkg::METER_CENTER_RST;
		end else if (wr_en) begin
			case (idx)
				dwe_pkg::REG_LOW_BATTERY_LEVEL:  cfg_q.low_battery_level  <= pwdata[7:0];
				dwe_pkg::REG_LOW_BATTERY_REPEAT: cfg_q.low_battery_repeat <= pwdata[9:0];
				dwe_pkg::REG_THRESHOLD_FLOOR:    cfg_q.threshold_floor    <= pwdata[6:0];
				dwe_pkg::REG_THRESHOLD_CEILING:  cfg_q.threshold_ceiling  <= pwdata[6:0];
				dwe_pkg::REG_METER_CENTER:       cfg_q.meter_center       <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		case (idx)
			dwe_pkg::REG_LOW_BATTERY_LEVEL:  prdata[7:0] = cfg_q.low_battery_level;
			dwe_pkg::REG_LOW_BATTERY_REPEAT: prdata[9:0] = cfg_q.low_battery_repeat;
			dwe_pkg::REG_THRESHOLD_FLOOR:    prdata[6:0] = cfg_q.threshold_floor;
			dwe_pkg::REG_THRESHOLD_CEILING:  prdata[6:0] = cfg_q.threshold_ceiling;
			dwe_pkg::REG_METER_CENTER:       prdata[7:0] = cfg_q.meter_center;
			default: prdata = '0;
		endcase
	end

endmodule

// ----- design/dwe_eval.sv -----
module dwe_eval #(
	parameter int COUNT_BITS = dwe_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  dwe_pkg::cfg_t         cfg,
	input  logic [COUNT_BITS-1:0] count_first,
	input  logic [COUNT_BITS-1:0] count_second,
	input  logic                  low_sensitivity,
	input  logic                  zero_request,
	input  logic [6:0]            threshold_raw,
	input  logic [7:0]            battery_level,
	output dwe_pkg::result_t      result
);

	localparam int DW = COUNT_BITS + 2;
	localparam logic signed [DW-1:0] DEV_LO = DW'(dwe_pkg::DEV_MIN);
	localparam logic signed [DW-1:0] DEV_HI = DW'(dwe_pkg::DEV_MAX);

	logic signed [COUNT_BITS:0] baseline_q;
	logic [6:0]                 held_q;
	logic [6:0]                 prev_pot_q;
	logic [9:0]                 countdown_q;

	logic signed [COUNT_BITS:0] diff_raw;
	logic signed [COUNT_BITS:0] diff;
	logic signed [COUNT_BITS:0] base_eff;
	logic signed [DW-1:0]       dev_wide;
	logic signed [8:0]          dev;
	logic [7:0]                 mag;
	logic [6:0]                 gap;
	logic [6:0]                 held_mv;
	logic [6:0]                 held_fl;
	logic [6:0]                 held_nx;
	logic                       batt_low;
	logic [9:0]                 countdown_nx;
	logic                       alarm;

	// Count difference and baseline
	always_comb begin
		diff_raw = $signed({1'b0, count_first}) - $signed({1'b0, count_second});
		diff     = low_sensitivity ? (diff_raw >>> 2) : diff_raw;
		base_eff = zero_request ? diff : baseline_q;
		dev_wide = $signed({diff[COUNT_BITS], diff}) - $signed({base_eff[COUNT_BITS], base_eff});
		if (dev_wide < DEV_LO) begin
			dev = 9'(dwe_pkg::DEV_MIN);
		end else if (dev_wide > DEV_HI) begin
			dev = 9'(dwe_pkg::DEV_MAX);
		end else begin
			dev = dev_wide[8:0];
		end
		mag = dev[8] ? 8'(-dev) : dev[7:0];
	end

	// Threshold tracking with hysteresis and clamping
	always_comb begin
		gap     = (threshold_raw > prev_pot_q) ? (threshold_raw - prev_pot_q)
			: (prev_pot_q - threshold_raw);
		held_mv = (gap > 7'd1) ? threshold_raw : held_q;
		held_fl = (held_mv < cfg.threshold_floor) ? cfg.threshold_floor : held_mv;
		held_nx = (held_fl > cfg.threshold_ceiling) ? cfg.threshold_ceiling : held_fl;
	end

	// Low battery repeat counter
	always_comb begin
		batt_low     = battery_level < cfg.low_battery_level;
		alarm        = 1'b0;
		countdown_nx = cfg.low_battery_repeat;
		if (batt_low) begin
			if (countdown_q != 10'd0) begin
				countdown_nx = countdown_q - 10'd1;
			end else begin
				alarm = 1'b1;
			end
		end
	end

	// Result fields
	always_comb begin
		result.meter_duty        = cfg.meter_center + dev[7:0];
		result.detect_led        = mag > {1'b0, held_nx};
		if (!result.detect_led) begin
			result.tone_mode = dwe_pkg::TONE_SILENT;
		end else if (!dev[8] && dev != 9'sd0) begin
			result.tone_mode = dwe_pkg::TONE_FAST;
		end else begin
			result.tone_mode = dwe_pkg::TONE_SLOW;
		end
		result.low_battery_alarm = alarm;
		result.sensor_error      = (count_first == '0) || (count_second == '0);
		result.active_threshold  = held_nx;
	end

	// State update once per window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q  <= (COUNT_BITS + 1)'(dwe_pkg::BASELINE_RST);
			held_q      <= dwe_pkg::THRESHOLD_RST;
			prev_pot_q  <= '0;
			countdown_q <= dwe_pkg::LOW_BATTERY_REPEAT_RST;
		end else if (advance) begin
			baseline_q  <= base_eff;
			held_q      <= held_nx;
			prev_pot_q  <= threshold_raw;
			countdown_q <= countdown_nx;
		end
	end

endmodule

// ----- design/detector_window_evaluator.sv -----
// A window is held in the input register, evaluated combinationally, and its result
// is registered in the result register before it is offered on the result channel.
// Throughput: one window per cycle; a stalled result register holds the input
// register, and input ready drops only when both are full.
// Reset: arst_n clears both stage valids, the evaluator state and loads the
// configuration registers with their reset values.
module detector_window_evaluator #(
	parameter int COUNT_BITS = dwe_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dwe_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [dwe_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [dwe_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                              pready,
	dwe_win_if.sink                           win,
	dwe_res_if.source                         res
);

	dwe_pkg::cfg_t    cfg;
	dwe_pkg::result_t result;
	dwe_pkg::result_t res_s2;

	logic                  valid_s1;
	logic                  valid_s2;
	logic                  advance;
	logic [COUNT_BITS-1:0] count_first_s1;
	logic [COUNT_BITS-1:0] count_second_s1;
	logic                  low_sensitivity_s1;
	logic                  zero_request_s1;
	logic [6:0]            threshold_raw_s1;
	logic [7:0]            battery_level_s1;

	dwe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage 1 moves on when the result register is free or being drained
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign win.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (win.ready) begin
			valid_s1 <= win.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (win.valid && win.ready) begin
			count_first_s1     <= win.count_first;
			count_second_s1    <= win.count_second;
			low_sensitivity_s1 <= win.low_sensitivity;
			zero_request_s1    <= win.zero_request;
			threshold_raw_s1   <= win.threshold_raw;
			battery_level_s1   <= win.battery_level;
		end
	end

	dwe_eval #(
		.COUNT_BITS (COUNT_BITS)
	) u_eval (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.cfg             (cfg),
		.count_first     (count_first_s1),
		.count_second    (count_second_s1),
		.low_sensitivity (low_sensitivity_s1),
		.zero_request    (zero_request_s1),
		.threshold_raw   (threshold_raw_s1),
		.battery_level   (battery_level_s1),
		.result          (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign res.valid             = valid_s2;
	assign res.meter_duty        = res_s2.meter_duty;
	assign res.tone_mode         = res_s2.tone_mode;
	assign res.detect_led        = res_s2.detect_led;
	assign res.low_battery_alarm = res_s2.low_battery_alarm;
	assign res.sensor_error      = res_s2.sensor_error;
	assign res.active_threshold  = res_s2.active_threshold;

endmodule

// ----- tb/detector_window_evaluator_tb.sv -----
module detector_window_evaluator_tb;

	localparam int CB = dwe_pkg::COUNT_BITS_DEF;
	localparam int HALF_PERIOD = 6;
	localparam int TIMEOUT_CYCLES = 200000;
	localparam int LONG_HOLD_CYCLES = 64;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_WINDOWS = 95;
	localparam int CNT_MAX = (1 << CB) - 1;
	// Index past the register map: a write there must change nothing
	localparam logic [2:0] UNUSED_REG = 3'd5;

	// One measurement window summary
	typedef struct packed {
		logic [CB-1:0] count_first;
		logic [CB-1:0] count_second;
		logic          low_sensitivity;
		logic          zero_request;
		logic [6:0]    threshold_raw;
		logic [7:0]    battery_level;
	} window_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [dwe_pkg::APB_ADDR_BITS-1:0] paddr = '0;
	logic [dwe_pkg::APB_DATA_BITS-1:0] pwdata = '0;
	logic [dwe_pkg::APB_DATA_BITS-1:0] prdata;
	logic pready;

	dwe_win_if #(.COUNT_BITS(CB)) win_ch ();
	dwe_res_if res_ch ();

	detector_window_evaluator #(.COUNT_BITS(CB)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.win(win_ch),
		.res(res_ch)
	);

	// Queues between stimulus, driver and monitor
	window_t pending_windows[$];
	dwe_pkg::result_t expected_results[$];
	window_t in_flight;
	dwe_pkg::result_t want_res;

	// Shadow of the configuration registers
	dwe_pkg::cfg_t cfg_shadow = '{dwe_pkg::LOW_BATTERY_LEVEL_RST, dwe_pkg::LOW_BATTERY_REPEAT_RST,
		dwe_pkg::THRESHOLD_FLOOR_RST, dwe_pkg::THRESHOLD_CEILING_RST, dwe_pkg::METER_CENTER_RST};

	// Evaluator state as the predictor sees it
	int         det_baseline;
	logic [6:0] thr_held;
	logic [6:0] pot_prev;
	logic [9:0] batt_countdown;

	// Traffic control shared by stimulus, driver and monitor
	int idle_pct = 13;
	int hold_req = 0;
	int hold_seen;
	int stall_left;
	bit failed = 1'b0;

	// Random window generator state
	int gen_base = dwe_pkg::BASELINE_RST;
	logic [6:0] gen_pot = '0;

	dwe_pkg::cfg_t phase_cfg [RANDOM_PHASES] = '{
		'{8'd200, 10'd1000, 7'd2,   7'd125, 8'd127},
		'{8'd0,   10'd0,    7'd0,   7'd127, 8'd0},
		'{8'd255, 10'd1023, 7'd127, 7'd127, 8'd255},
		'{8'd128, 10'd3,    7'd10,  7'd60,  8'd128},
		'{8'd100, 10'd1,    7'd0,   7'd0,   8'd64},
		'{8'd180, 10'd7,    7'd50,  7'd30,  8'd200},
		'{8'd230, 10'd2,    7'd5,   7'd100, 8'd127}
	};
	int phase_ls [RANDOM_PHASES] = '{10, 50, 0, 90, 20, 100, 40};
	int phase_idle [RANDOM_PHASES] = '{13, 13, 0, 13, 13, 13, 13};

	// Clock and reset
	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Known values on the window channel and result ready from time zero
	initial begin
		win_ch.valid = 1'b0;
		win_ch.count_first = '0;
		win_ch.count_second = '0;
		win_ch.low_sensitivity = 1'b0;
		win_ch.zero_request = 1'b0;
		win_ch.threshold_raw = '0;
		win_ch.battery_level = '0;
		res_ch.ready = 1'b0;
	end

	initial begin
		#(2 * HALF_PERIOD * TIMEOUT_CYCLES);
		$display("Test completed with failures");
		$finish;
	end

	// Predicts the result of one window and advances the evaluator state
	function automatic dwe_pkg::result_t eval_window(window_t w);
		int diff;
		int dev;
		int mag;
		int gap;
		dwe_pkg::result_t r;
		diff = int'(w.count_first) - int'(w.count_second);
		if (w.low_sensitivity) begin
			diff = diff >>> 2;
		end
		if (w.zero_request) begin
			det_baseline = diff;
		end
		dev = diff - det_baseline;
		if (dev < dwe_pkg::DEV_MIN) begin
			dev = dwe_pkg::DEV_MIN;
		end else if (dev > dwe_pkg::DEV_MAX) begin
			dev = dwe_pkg::DEV_MAX;
		end

		// Threshold follows the pot only on a move of more than one step
		gap = int'(w.threshold_raw) - int'(pot_prev);
		if (gap > 1 || gap < -1) begin
			thr_held = w.threshold_raw;
		end
		pot_prev = w.threshold_raw;
		if (thr_held < cfg_shadow.threshold_floor) begin
			thr_held = cfg_shadow.threshold_floor;
		end
		if (thr_held > cfg_shadow.threshold_ceiling) begin
			thr_held = cfg_shadow.threshold_ceiling;
		end

		mag = (dev < 0) ? -dev : dev;
		if (mag > int'(thr_held)) begin
			r.tone_mode = (dev > 0) ? dwe_pkg::TONE_FAST : dwe_pkg::TONE_SLOW;
			r.detect_led = 1'b1;
		end else begin
			r.tone_mode = dwe_pkg::TONE_SILENT;
			r.detect_led = 1'b0;
		end

		// Low battery repeat counter
		r.low_battery_alarm = 1'b0;
		if (w.battery_level < cfg_shadow.low_battery_level) begin
			if (batt_countdown != '0) begin
				batt_countdown = batt_countdown - 10'd1;
			end else begin
				batt_countdown = cfg_shadow.low_battery_repeat;
				r.low_battery_alarm = 1'b1;
			end
		end else begin
			batt_countdown = cfg_shadow.low_battery_repeat;
		end

		r.meter_duty = 8'(int'(cfg_shadow.meter_center) + dev);
		r.sensor_error = (w.count_first == '0) || (w.count_second == '0);
		r.active_threshold = thr_held;
		return r;
	endfunction

	function automatic window_t make_window(int c1, int c2, bit ls, bit zr, int pot, int batt);
		window_t w;
		w.count_first = CB'(c1);
		w.count_second = CB'(c2);
		w.low_sensitivity = ls;
		w.zero_request = zr;
		w.threshold_raw = 7'(pot);
		w.battery_level = 8'(batt);
		return w;
	endfunction

	// Random window: mostly differences near the captured baseline, some noise
	function automatic window_t rand_window(int ls_pct, bit force_zero);
		window_t w;
		int sel;
		int d;
		int raw;
		int lo;
		int hi;
		int c2;
		int batt;
		w.low_sensitivity = ($urandom_range(0, 99) < ls_pct);
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			case ($urandom_range(0, 2))
				0: w.count_first = '0;
				1: w.count_first = CB'(CNT_MAX);
				default: w.count_first = CB'($urandom);
			endcase
			case ($urandom_range(0, 2))
				0: w.count_second = '0;
				1: w.count_second = CB'(CNT_MAX);
				default: w.count_second = CB'($urandom);
			endcase
		end else if (sel < 30) begin
			w.count_first = CB'($urandom);
			w.count_second = CB'($urandom);
		end else begin
			d = gen_base + int'($urandom_range(0, 400)) - 200;
			raw = w.low_sensitivity ? d * 4 + int'($urandom_range(0, 3)) : d;
			if (raw > CNT_MAX) raw = CNT_MAX;
			if (raw < -CNT_MAX) raw = -CNT_MAX;
			lo = (raw < 0) ? -raw : 0;
			hi = (raw > 0) ? CNT_MAX - raw : CNT_MAX;
			c2 = $urandom_range(hi, lo);
			w.count_second = CB'(c2);
			w.count_first = CB'(c2 + raw);
		end
		w.zero_request = force_zero || ($urandom_range(0, 99) < 8);
		if (w.zero_request) begin
			gen_base = int'(w.count_first) - int'(w.count_second);
			if (w.low_sensitivity) gen_base = gen_base >>> 2;
		end

		// Pot mostly still or jittering by one step
		sel = $urandom_range(0, 9);
		if (sel < 6) begin
			w.threshold_raw = gen_pot;
		end else if (sel < 8) begin
			w.threshold_raw = $urandom_range(0, 1) ? gen_pot + 7'd1 : gen_pot - 7'd1;
		end else begin
			w.threshold_raw = 7'($urandom);
		end
		gen_pot = w.threshold_raw;

		// Battery around the low level, sometimes anywhere
		if ($urandom_range(0, 9) < 5) begin
			w.battery_level = 8'($urandom);
		end else begin
			batt = int'(cfg_shadow.low_battery_level) + int'($urandom_range(0, 6)) - 3;
			if (batt < 0) batt = 0;
			if (batt > 255) batt = 255;
			w.battery_level = 8'(batt);
		end
		return w;
	endfunction

	// APB write: setup then access, register taken when pready is high
	task automatic apb_write(logic [2:0] idx, logic [dwe_pkg::APB_DATA_BITS-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			dwe_pkg::REG_LOW_BATTERY_LEVEL:  cfg_shadow.low_battery_level = data[7:0];
			dwe_pkg::REG_LOW_BATTERY_REPEAT: cfg_shadow.low_battery_repeat = data[9:0];
			dwe_pkg::REG_THRESHOLD_FLOOR:    cfg_shadow.threshold_floor = data[6:0];
			dwe_pkg::REG_THRESHOLD_CEILING:  cfg_shadow.threshold_ceiling = data[6:0];
			dwe_pkg::REG_METER_CENTER:       cfg_shadow.meter_center = data[7:0];
			default: ;
		endcase
	endtask

	// All five registers, with junk in the unused upper bits
	task automatic apply_config(dwe_pkg::cfg_t c);
		logic [31:0] junk;
		junk = $urandom;
		apb_write(dwe_pkg::REG_LOW_BATTERY_LEVEL, {junk[31:8], c.low_battery_level});
		apb_write(dwe_pkg::REG_LOW_BATTERY_REPEAT, {junk[31:10], c.low_battery_repeat});
		apb_write(dwe_pkg::REG_THRESHOLD_FLOOR, {junk[31:7], c.threshold_floor});
		apb_write(dwe_pkg::REG_THRESHOLD_CEILING, {junk[31:7], c.threshold_ceiling});
		apb_write(dwe_pkg::REG_METER_CENTER, {junk[31:8], c.meter_center});
	endtask

	// Sender paused until every window has come back out
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_windows.size() != 0 || win_ch.valid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			failed = 1'b1;
		end
	endtask

	// Window driver: predicts on each accepted transaction, then offers the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_ch.valid <= 1'b0;
			det_baseline = dwe_pkg::BASELINE_RST;
			thr_held = dwe_pkg::THRESHOLD_RST;
			pot_prev = '0;
			batt_countdown = dwe_pkg::LOW_BATTERY_REPEAT_RST;
		end else begin
			if (win_ch.valid && win_ch.ready) begin
				expected_results.push_back(eval_window(in_flight));
			end
			if (!win_ch.valid || win_ch.ready) begin
				if (pending_windows.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					in_flight = pending_windows.pop_front();
					win_ch.count_first <= in_flight.count_first;
					win_ch.count_second <= in_flight.count_second;
					win_ch.low_sensitivity <= in_flight.low_sensitivity;
					win_ch.zero_request <= in_flight.zero_request;
					win_ch.threshold_raw <= in_flight.threshold_raw;
					win_ch.battery_level <= in_flight.battery_level;
					win_ch.valid <= 1'b1;
				end else begin
					win_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random and long stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_seen = 0;
			stall_left = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with no window pending");
					failed = 1'b1;
				end else begin
					want_res = expected_results.pop_front();
					check_field("meter_duty", want_res.meter_duty, res_ch.meter_duty);
					check_field("tone_mode", want_res.tone_mode, res_ch.tone_mode);
					check_field("detect_led", want_res.detect_led, res_ch.detect_led);
					check_field("low_battery_alarm", want_res.low_battery_alarm,
						res_ch.low_battery_alarm);
					check_field("sensor_error", want_res.sensor_error, res_ch.sensor_error);
					check_field("active_threshold", want_res.active_threshold,
						res_ch.active_threshold);
				end
			end
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				stall_left = LONG_HOLD_CYCLES;
			end
			if (stall_left != 0) begin
				stall_left = stall_left - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	// Stimulus
	initial begin
		wait (arst_n === 1'b1);
		repeat (2) @(posedge clk);

		// Reset configuration: extremes, rounding, zero capture, pot hysteresis
		pending_windows.push_back(make_window(0, 0, 0, 0, 0, 255));
		pending_windows.push_back(make_window(CNT_MAX, 0, 0, 0, 1, 0));
		pending_windows.push_back(make_window(0, CNT_MAX, 0, 0, 1, 199));
		pending_windows.push_back(make_window(1000, 873, 0, 0, 1, 200));
		pending_windows.push_back(make_window(100, 107, 1, 1, 1, 255));
		pending_windows.push_back(make_window(100, 105, 1, 0, 1, 255));
		pending_windows.push_back(make_window(100, 101, 1, 0, 1, 255));
		pending_windows.push_back(make_window(140, 100, 1, 0, 1, 255));
		pending_windows.push_back(make_window(60, 100, 1, 0, 1, 255));
		pending_windows.push_back(make_window(500, 500, 0, 0, 127, 255));
		pending_windows.push_back(make_window(500, 500, 0, 0, 126, 255));
		pending_windows.push_back(make_window(500, 500, 0, 0, 0, 255));
		// Full-width baseline, then the opposite extreme: no 16-bit wrap
		pending_windows.push_back(make_window(CNT_MAX, 0, 0, 1, 0, 255));
		pending_windows.push_back(make_window(0, CNT_MAX, 0, 0, 0, 255));
		pending_windows.push_back(make_window(1, 1, 0, 1, 0, 255));
		pending_windows.push_back(make_window(CNT_MAX, CNT_MAX - 1, 1, 0, 64, 100));
		wait_drained();

		// Meter wrap, floor above ceiling, alarm on every low window
		apply_config('{8'd255, 10'd0, 7'd100, 7'd20, 8'd255});
		apb_write(UNUSED_REG, $urandom);
		pending_windows.push_back(make_window(300, 100, 0, 0, 0, 0));
		pending_windows.push_back(make_window(100, 300, 0, 0, 0, 0));
		pending_windows.push_back(make_window(1, 1, 0, 0, 50, 254));
		pending_windows.push_back(make_window(5, 5, 0, 0, 50, 255));
		pending_windows.push_back(make_window(5, 5, 0, 0, 90, 0));
		pending_windows.push_back(make_window(12, 1, 0, 0, 90, 0));
		wait_drained();

		// Random phases over a range of settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			apply_config(phase_cfg[p]);
			idle_pct = phase_idle[p];
			for (int i = 0; i < PHASE_WINDOWS; i++) begin
				pending_windows.push_back(rand_window(phase_ls[p], i == 0));
			end
			if (p == 3) begin
				hold_req = hold_req + 1;
			end
			wait_drained();
		end

		repeat (6) @(posedge clk);
		if (!failed && expected_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
